>>> src/rls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants for the RGB LED strip serializer.
// ----------------------------------------------------------------------------
package rls_pkg;

	localparam int MAX_LEDS_DEF = 64;

	// Input word modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_LED_COUNT  = 3'd0;
	localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
	localparam logic [2:0] REG_ONE_LOW    = 3'd2;
	localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
	localparam logic [2:0] REG_ZERO_LOW   = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [6:0] LED_COUNT_RST = 7'd64;
	localparam logic [7:0] ONE_HIGH_RST  = 8'd48;
	localparam logic [7:0] ONE_LOW_RST   = 8'd17;
	localparam logic [7:0] ZERO_HIGH_RST = 8'd18;
	localparam logic [7:0] ZERO_LOW_RST  = 8'd66;

	// Index of the last bit in one LED: three bytes.
	localparam logic [4:0] LAST_BIT = 5'd23;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_t;

	typedef struct packed {
		logic line_level;
		logic sending;
		logic frame_done;
		logic rejected;
	} out_t;

endpackage

>>> src/rls_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_frame_mem
// Frame buffer: one 24-bit GRB word per LED, registered read, zero sweep
// after reset.
// ----------------------------------------------------------------------------
module rls_frame_mem #(
	parameter int MaxLeds = rls_pkg::MAX_LEDS_DEF,
	parameter int LedW    = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [LedW-1:0] wr_addr,
	input  logic [23:0]     wr_data,
	input  logic [LedW-1:0] rd_addr,
	output logic [23:0]     rd_data,
	output logic            clearing
);
	import rls_pkg::*;

	logic [23:0]     mem [MaxLeds];
	logic            clr_q;
	logic [LedW-1:0] clr_addr_q;
	logic [23:0]     rd_data_q;

	// The sweep walks every entry once, writing zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (int'(clr_addr_q) == MaxLeds - 1) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_q;

endmodule

>>> src/rgb_led_strip_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer_top
// Single-wire RGB LED strip driver with a frame buffer and pulse timer.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while in_ready is high and
// registers one result word for each; a two-entry output stage lets input
// continue while a result waits. A write word stores an LED colour, a start
// word begins a frame, and each tick word advances the pulse timer by one, so
// the line timing is set entirely by the rate of tick words. After reset the
// frame buffer is swept to zero, one LED per cycle; input is held off until
// the sweep completes while configuration writes are still taken. During a
// frame the buffer is read one LED ahead, so the colour of the next LED is
// already registered when the current LED's 24 bits run out.
// ----------------------------------------------------------------------------
module rgb_led_strip_serializer_top #(
	parameter int MAX_LEDS = rls_pkg::MAX_LEDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rls_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rls_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [7:0]    cfg_data
);
	import rls_pkg::*;

	// LED index width; at least one bit so a single-LED strip still works.
	localparam int LED_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	// Configuration registers.
	logic [6:0] led_count_q;
	logic [7:0] one_high_q;
	logic [7:0] one_low_q;
	logic [7:0] zero_high_q;
	logic [7:0] zero_low_q;

	// Frame sequencer state.
	logic             busy_q;
	logic [LED_W-1:0] cur_led_q;
	logic [4:0]       bit_cnt_q;
	logic             low_phase_q;
	logic [7:0]       phase_ticks_q;
	logic [23:0]      shreg_q;
	logic [23:0]      head_word_q;

	// Output stage.
	logic out_valid_q;
	out_t out_q;
	logic skid_valid_q;
	out_t skid_q;

	// Memory interface.
	logic             clearing;
	logic             mem_we;
	logic [LED_W-1:0] mem_wr_addr;
	logic [23:0]      mem_wr_data;
	logic [LED_W-1:0] mem_rd_addr;
	logic [23:0]      mem_rd_data;

	logic       accept;
	logic       idx_ok;
	logic [7:0] len_raw;
	logic [7:0] len;
	logic [7:0] ticks_inc;
	logic       phase_end;
	logic       led_end;
	logic       frame_end;
	int         eff_count;
	out_t       res;

	assign in_ready = !skid_valid_q && !clearing;
	assign accept   = in_valid && in_ready;

	// Colour writes beyond the buffer are dropped silently.
	assign idx_ok = int'(in_data.led_index) < MAX_LEDS;

	assign mem_we      = accept && !busy_q && (in_data.mode == MODE_WRITE) && idx_ok;
	assign mem_wr_addr = LED_W'(in_data.led_index);
	assign mem_wr_data = {in_data.green, in_data.red, in_data.blue};

	// Look one LED ahead; the wrap only matters on a frame's last LED, whose
	// successor is never used.
	assign mem_rd_addr = (int'(cur_led_q) == MAX_LEDS - 1) ? '0 : cur_led_q + 1'b1;

	rls_frame_mem #(
		.MaxLeds(MAX_LEDS),
		.LedW   (LED_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.clearing(clearing)
	);

	// A zero LED count behaves as one, and counts above the buffer are capped.
	always_comb begin
		if (led_count_q == '0) begin
			eff_count = 1;
		end else if (int'(led_count_q) > MAX_LEDS) begin
			eff_count = MAX_LEDS;
		end else begin
			eff_count = int'(led_count_q);
		end
	end

	// Phase length follows the bit being sent; zero lengths act as one.
	always_comb begin
		if (!low_phase_q) begin
			len_raw = shreg_q[23] ? one_high_q : zero_high_q;
		end else begin
			len_raw = shreg_q[23] ? one_low_q : zero_low_q;
		end
		len = (len_raw == '0) ? 8'd1 : len_raw;
	end

	assign ticks_inc = phase_ticks_q + 8'd1;
	assign phase_end = ticks_inc >= len;
	assign led_end   = bit_cnt_q == LAST_BIT;
	assign frame_end = int'(cur_led_q) + 1 >= eff_count;

	// Result of the word being accepted, taken from the state before it.
	always_comb begin
		res            = '0;
		res.line_level = busy_q && !low_phase_q;
		res.sending    = busy_q;
		case (in_data.mode)
			MODE_WRITE: begin
				res.rejected = busy_q;
			end
			MODE_START: begin
				res.rejected = busy_q;
				res.sending  = 1'b1;
			end
			MODE_TICK: begin
				res.frame_done = busy_q && phase_end && low_phase_q && led_end && frame_end;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RST;
			one_high_q  <= ONE_HIGH_RST;
			one_low_q   <= ONE_LOW_RST;
			zero_high_q <= ZERO_HIGH_RST;
			zero_low_q  <= ZERO_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LED_COUNT: led_count_q <= cfg_data[6:0];
				REG_ONE_HIGH:  one_high_q  <= cfg_data;
				REG_ONE_LOW:   one_low_q   <= cfg_data;
				REG_ZERO_HIGH: zero_high_q <= cfg_data;
				REG_ZERO_LOW:  zero_low_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// LED 0 is mirrored in a register so a start can load it without waiting
	// for a memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_word_q <= '0;
		end else if (mem_we && (in_data.led_index == '0)) begin
			head_word_q <= mem_wr_data;
		end
	end

	// Frame sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			cur_led_q     <= '0;
			bit_cnt_q     <= '0;
			low_phase_q   <= 1'b0;
			phase_ticks_q <= '0;
			shreg_q       <= '0;
		end else if (accept) begin
			case (in_data.mode)
				MODE_START: begin
					if (!busy_q) begin
						busy_q        <= 1'b1;
						cur_led_q     <= '0;
						bit_cnt_q     <= '0;
						low_phase_q   <= 1'b0;
						phase_ticks_q <= '0;
						shreg_q       <= head_word_q;
					end
				end
				MODE_TICK: begin
					if (busy_q) begin
						if (!phase_end) begin
							phase_ticks_q <= ticks_inc;
						end else begin
							phase_ticks_q <= '0;
							if (!low_phase_q) begin
								low_phase_q <= 1'b1;
							end else begin
								low_phase_q <= 1'b0;
								if (!led_end) begin
									bit_cnt_q <= bit_cnt_q + 5'd1;
									shreg_q   <= {shreg_q[22:0], 1'b0};
								end else if (frame_end) begin
									busy_q    <= 1'b0;
									cur_led_q <= '0;
									bit_cnt_q <= '0;
									shreg_q   <= '0;
								end else begin
									// The next LED's word was prefetched.
									cur_led_q <= cur_led_q + 1'b1;
									bit_cnt_q <= '0;
									shreg_q   <= mem_rd_data;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!accept) begin
				out_valid_q <= 1'b0;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= accept;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (!out_valid_q) begin
			if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
